// File: hdl/biou_pkg.sv
// Shared constants for the box IoU pipeline.
// No dependencies; used by every module of the block.
package biou_pkg;

  // Default coordinate width and fraction width of the result.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Number of coordinate fields in one input beat (two boxes, two corners, x and y).
  localparam int NUM_COORDS = 8;

  // Round a bit count up to whole bytes.
  function automatic int byte_pad(input int nbits);
    return ((nbits + 7) / 8) * 8;
  endfunction

endpackage

// File: hdl/biou_geom.sv
// Box geometry stages: corner ordering, then intersection and side lengths.
// Depends on biou_pkg for the default coordinate width.
module biou_geom #(
  parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] ax0,
  input  logic signed [COORD_BITS-1:0] ay0,
  input  logic signed [COORD_BITS-1:0] ax1,
  input  logic signed [COORD_BITS-1:0] ay1,
  input  logic signed [COORD_BITS-1:0] bx0,
  input  logic signed [COORD_BITS-1:0] by0,
  input  logic signed [COORD_BITS-1:0] bx1,
  input  logic signed [COORD_BITS-1:0] by1,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic        [COORD_BITS-1:0] a_w,
  output logic        [COORD_BITS-1:0] a_h,
  output logic        [COORD_BITS-1:0] b_w,
  output logic        [COORD_BITS-1:0] b_h,
  output logic        [COORD_BITS-1:0] i_w,
  output logic        [COORD_BITS-1:0] i_h,
  output logic                         empty
);

  localparam int C = COORD_BITS;

  // stage 1: ordered corners
  logic               v1;
  logic signed [C-1:0] axs, axe, ays, aye, bxs, bxe, bys, bye;
  // stage 1 and stage 2 handshake
  logic               rdy1, rdy2;

  // stage 2 combinational
  logic signed [C-1:0] ixs, ixe, iys, iye;
  logic signed [C:0]   dix, diy, dax, day, dbx, dby;

  assign rdy2     = !out_valid || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      axs <= (ax0 < ax1) ? ax0 : ax1;
      axe <= (ax0 > ax1) ? ax0 : ax1;
      ays <= (ay0 < ay1) ? ay0 : ay1;
      aye <= (ay0 > ay1) ? ay0 : ay1;
      bxs <= (bx0 < bx1) ? bx0 : bx1;
      bxe <= (bx0 > bx1) ? bx0 : bx1;
      bys <= (by0 < by1) ? by0 : by1;
      bye <= (by0 > by1) ? by0 : by1;
    end
  end

  always_comb begin
    ixs = (axs > bxs) ? axs : bxs;
    ixe = (axe < bxe) ? axe : bxe;
    iys = (ays > bys) ? ays : bys;
    iye = (aye < bye) ? aye : bye;
    // one extra bit so the signed differences never wrap
    dix = {ixe[C-1], ixe} - {ixs[C-1], ixs};
    diy = {iye[C-1], iye} - {iys[C-1], iys};
    dax = {axe[C-1], axe} - {axs[C-1], axs};
    day = {aye[C-1], aye} - {ays[C-1], ays};
    dbx = {bxe[C-1], bxe} - {bxs[C-1], bxs};
    dby = {bye[C-1], bye} - {bys[C-1], bys};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      a_w   <= dax[C-1:0];
      a_h   <= day[C-1:0];
      b_w   <= dbx[C-1:0];
      b_h   <= dby[C-1:0];
      i_w   <= dix[C-1:0];
      i_h   <= diy[C-1:0];
      // no positive area when either side is zero or negative
      empty <= dix[C] || (dix == '0) || diy[C] || (diy == '0);
    end
  end

endmodule

// File: hdl/biou_area.sv
// Area stages: three side-length products, then the union area.
// Depends on biou_pkg for the default coordinate width.
module biou_area #(
  parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [COORD_BITS-1:0]   a_w,
  input  logic [COORD_BITS-1:0]   a_h,
  input  logic [COORD_BITS-1:0]   b_w,
  input  logic [COORD_BITS-1:0]   b_h,
  input  logic [COORD_BITS-1:0]   i_w,
  input  logic [COORD_BITS-1:0]   i_h,
  input  logic                    in_empty,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2*COORD_BITS-1:0] area_i,
  output logic [2*COORD_BITS:0]   area_u,
  output logic                    empty
);

  localparam int AW = 2 * COORD_BITS;

  logic          v3, e3;
  logic [AW-1:0] pa, pb, pi;
  logic          rdy3, rdy4;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign in_ready = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && in_valid) begin
      pa <= AW'(a_w) * AW'(a_h);
      pb <= AW'(b_w) * AW'(b_h);
      pi <= AW'(i_w) * AW'(i_h);
      e3 <= in_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && v3) begin
      area_i <= pi;
      area_u <= {1'b0, pa} + {1'b0, pb} - {1'b0, pi};
      empty  <= e3;
    end
  end

endmodule

// File: hdl/biou_div.sv
// Pipelined restoring divider: one quotient bit per stage, FRAC_BITS+1 stages.
// Depends on biou_pkg for default widths.
module biou_div #(
  parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2*COORD_BITS-1:0] num,
  input  logic [2*COORD_BITS:0]   den,
  input  logic                    in_empty,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [FRAC_BITS:0]      iou,
  output logic                    empty
);

  localparam int RW = 2 * COORD_BITS + 1;
  localparam int NS = FRAC_BITS + 1;

  logic                 vld [0:NS-1];
  logic                 emp [0:NS-1];
  logic [RW-1:0]        rem [0:NS-1];
  logic [RW-1:0]        dv  [0:NS-1];
  logic [FRAC_BITS:0]   quo [0:NS-1];
  logic                 rdy [0:NS];

  logic [RW-1:0] r0;
  logic          ge0;

  assign rdy[NS]  = out_ready;
  assign in_ready = rdy[0];

  // integer part: num <= den, so this bit is set only when equal
  always_comb begin
    r0  = {1'b0, num};
    ge0 = (r0 >= den);
  end

  assign rdy[0] = !vld[0] || rdy[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem[0] <= ge0 ? (r0 - den) : r0;
      quo[0] <= (FRAC_BITS + 1)'(ge0);
      dv[0]  <= den;
      emp[0] <= in_empty;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    logic [RW:0] t;
    logic [RW:0] d;
    logic        ge;

    always_comb begin
      t  = {rem[k-1], 1'b0};
      d  = {1'b0, dv[k-1]};
      ge = (t >= d);
    end

    assign rdy[k] = !vld[k] || rdy[k+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && vld[k-1]) begin
        rem[k] <= ge ? RW'(t - d) : t[RW-1:0];
        quo[k] <= {quo[k-1][FRAC_BITS-1:0], ge};
        dv[k]  <= dv[k-1];
        emp[k] <= emp[k-1];
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign iou       = emp[NS-1] ? '0 : quo[NS-1];
  assign empty     = emp[NS-1];

endmodule

// File: hdl/box_iou_core.sv
// Top level of the axis-aligned box IoU pipeline.
// Depends on biou_pkg, biou_geom, biou_area and biou_div.
//
// Channel  | Dir | Beat contents (low bits first)
// ---------+-----+----------------------------------------------------------
// s_axis   | in  | a_x_first, a_y_first, a_x_second, a_y_second,
//          |     | b_x_first, b_y_first, b_x_second, b_y_second
// m_axis   | out | iou (Q1.FRAC_BITS), overlap_empty, zero pad to bytes
//
// The pipeline has two geometry stages, two area stages and one divider
// stage per quotient bit. One beat per cycle in and out while m_axis_tready
// is high. rst is synchronous and clears only the valid bits. Every stage
// holds while the one after it is full and stalled, so empty stages keep
// filling under a stalled output and nothing is dropped or repeated.
module box_iou_core #(
  parameter int COORD_BITS = biou_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = biou_pkg::FRAC_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_axis_tvalid,
  output logic                                         s_axis_tready,
  // a_x_first, a_y_first, a_x_second, a_y_second,
  // b_x_first, b_y_first, b_x_second, b_y_second
  input  logic [biou_pkg::NUM_COORDS*COORD_BITS-1:0]   s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // iou, overlap_empty, zero pad
  output logic [biou_pkg::byte_pad(FRAC_BITS+2)-1:0]   m_axis_tdata
);

  localparam int C     = COORD_BITS;
  localparam int OUT_W = biou_pkg::byte_pad(FRAC_BITS + 2);

  // unpacked coordinates
  logic signed [C-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;

  // geometry -> area
  logic         g_valid, g_ready, g_empty;
  logic [C-1:0] a_w, a_h, b_w, b_h, i_w, i_h;

  // area -> divider
  logic           ar_valid, ar_ready, ar_empty;
  logic [2*C-1:0] area_i;
  logic [2*C:0]   area_u;

  // divider result
  logic [FRAC_BITS:0] iou;
  logic               overlap_empty;

  assign ax0 = signed'(s_axis_tdata[0*C +: C]);
  assign ay0 = signed'(s_axis_tdata[1*C +: C]);
  assign ax1 = signed'(s_axis_tdata[2*C +: C]);
  assign ay1 = signed'(s_axis_tdata[3*C +: C]);
  assign bx0 = signed'(s_axis_tdata[4*C +: C]);
  assign by0 = signed'(s_axis_tdata[5*C +: C]);
  assign bx1 = signed'(s_axis_tdata[6*C +: C]);
  assign by1 = signed'(s_axis_tdata[7*C +: C]);

  // order corners, intersect, side lengths
  biou_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .ax0       (ax0),
    .ay0       (ay0),
    .ax1       (ax1),
    .ay1       (ay1),
    .bx0       (bx0),
    .by0       (by0),
    .bx1       (bx1),
    .by1       (by1),
    .out_valid (g_valid),
    .out_ready (g_ready),
    .a_w       (a_w),
    .a_h       (a_h),
    .b_w       (b_w),
    .b_h       (b_h),
    .i_w       (i_w),
    .i_h       (i_h),
    .empty     (g_empty)
  );

  // areas and union
  biou_area #(
    .COORD_BITS (COORD_BITS)
  ) u_area (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_valid),
    .in_ready  (g_ready),
    .a_w       (a_w),
    .a_h       (a_h),
    .b_w       (b_w),
    .b_h       (b_h),
    .i_w       (i_w),
    .i_h       (i_h),
    .in_empty  (g_empty),
    .out_valid (ar_valid),
    .out_ready (ar_ready),
    .area_i    (area_i),
    .area_u    (area_u),
    .empty     (ar_empty)
  );

  // intersection / union, truncated
  biou_div #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ar_valid),
    .in_ready  (ar_ready),
    .num       (area_i),
    .den       (area_u),
    .in_empty  (ar_empty),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .iou       (iou),
    .empty     (overlap_empty)
  );

  assign m_axis_tdata = OUT_W'({overlap_empty, iou});

endmodule

// File: tb/sv/testbench.sv
// Self-checking bench for box_iou_core: streams box pairs, predicts IoU per beat.
// Depends on biou_pkg and the box_iou_core RTL; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;

  localparam int CB = biou_pkg::COORD_BITS_DEF;
  localparam int FB = biou_pkg::FRAC_BITS_DEF;
  localparam int IW = biou_pkg::NUM_COORDS * CB;
  localparam int OW = biou_pkg::byte_pad(FB + 2);
  localparam int LATENCY = FB + 5;
  localparam int RANDOM_PAIRS = 1700;

  typedef logic [CB-1:0] coord_t;

  // One expected output beat: Q1.FB ratio and the empty-overlap flag.
  typedef struct packed {
    logic [FB:0] ratio;
    logic        empty;
  } iou_res_t;

  // Predicts IoU for every accepted box pair and checks output beats in order.
  class iou_scoreboard;
    iou_res_t expected_q[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("%0t mismatch: %s", $realtime, msg);
    endfunction

    function longint lo(longint p, longint q);
      return (p < q) ? p : q;
    endfunction

    function longint hi(longint p, longint q);
      return (p > q) ? p : q;
    endfunction

    function void note_pair(logic [IW-1:0] beat);
      longint   c[8];
      longint   axs, axe, ays, aye, bxs, bxe, bys, bye;
      longint   ixs, ixe, iys, iye;
      longint   area_a, area_b, area_i, area_u;
      iou_res_t r;
      for (int i = 0; i < 8; i++) begin
        c[i] = longint'(signed'(beat[i*CB +: CB]));
      end
      axs = lo(c[0], c[2]); axe = hi(c[0], c[2]);
      ays = lo(c[1], c[3]); aye = hi(c[1], c[3]);
      bxs = lo(c[4], c[6]); bxe = hi(c[4], c[6]);
      bys = lo(c[5], c[7]); bye = hi(c[5], c[7]);
      ixs = hi(axs, bxs); ixe = lo(axe, bxe);
      iys = hi(ays, bys); iye = lo(aye, bye);
      r.ratio = '0;
      r.empty = 1'b1;
      if (ixe > ixs && iye > iys) begin
        area_a = (axe - axs) * (aye - ays);
        area_b = (bxe - bxs) * (bye - bys);
        area_i = (ixe - ixs) * (iye - iys);
        area_u = area_a + area_b - area_i;
        // floor(area_i * 2^FB / area_u); at most 2^48 / 1, fits in 64 bits
        r.ratio = (FB+1)'((area_i << FB) / area_u);
        r.empty = 1'b0;
      end
      expected_q.push_back(r);
    endfunction

    function void check_beat(logic [OW-1:0] beat);
      iou_res_t want;
      if (expected_q.size() == 0) begin
        flag($sformatf("unexpected beat %h", beat));
        return;
      end
      want = expected_q.pop_front();
      if (beat[FB:0] !== want.ratio)
        flag($sformatf("iou exp %0d got %0d", want.ratio, beat[FB:0]));
      if (beat[FB+1] !== want.empty)
        flag($sformatf("overlap_empty exp %0b got %0b", want.empty, beat[FB+1]));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [IW-1:0] s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [OW-1:0] m_axis_tdata;

  int unsigned send_idle_pct = 33;
  int unsigned recv_idle_pct = 82;

  iou_scoreboard sb;

  box_iou_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Output side: check the beat taken at this edge, then pick next tready.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    m_axis_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one pair, idling first at the current rate; note it once accepted.
  task automatic send_beat(input logic [IW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_pair(d);
  endtask

  // Corners in field order: box A first/second, then box B first/second.
  task automatic send_boxes(input int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
    send_beat({coord_t'(by1), coord_t'(bx1), coord_t'(by0), coord_t'(bx0),
               coord_t'(ay1), coord_t'(ax1), coord_t'(ay0), coord_t'(ax0)});
  endtask

  function automatic int any_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  // Side length class: mostly small boxes, now and then full range.
  function automatic int any_span();
    case ($urandom_range(3))
      0: return $urandom_range(15);
      1: return $urandom_range(255);
      2: return $urandom_range(4095);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Mostly overlapping pairs so the division path sees real work.
  task automatic send_random_pair();
    int kind, w, h, dx, dy;
    int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, t;
    kind = $urandom_range(99);
    ax0 = any_coord(); ay0 = any_coord();
    w = any_span(); h = any_span();
    ax1 = ax0 + w; ay1 = ay0 + h;
    bx0 = ax0; by0 = ay0; bx1 = ax1; by1 = ay1;
    if (kind < 45) begin
      // B shifted and resized around A
      dx = w + 1; dy = h + 1;
      bx0 = ax0 + int'($urandom_range(2 * dx)) - dx;
      by0 = ay0 + int'($urandom_range(2 * dy)) - dy;
      bx1 = ax1 + int'($urandom_range(2 * dx)) - dx;
      by1 = ay1 + int'($urandom_range(2 * dy)) - dy;
    end else if (kind < 55) begin
      // identical boxes
    end else if (kind < 65) begin
      // zero width or zero height on one of the boxes
      if ($urandom_range(1)) ax1 = ax0;
      else by1 = by0;
    end else if (kind < 75) begin
      // B nested in A
      bx0 = ax0 + int'($urandom_range(w));
      by0 = ay0 + int'($urandom_range(h));
      bx1 = bx0 + int'($urandom_range(ax0 + w - bx0));
      by1 = by0 + int'($urandom_range(ay0 + h - by0));
    end else if (kind < 90) begin
      ax1 = any_coord(); ay1 = any_coord();
      bx0 = any_coord(); by0 = any_coord();
      bx1 = any_coord(); by1 = any_coord();
    end else begin
      ax0 = int'($urandom_range(16)) - 8; ay0 = int'($urandom_range(16)) - 8;
      ax1 = int'($urandom_range(16)) - 8; ay1 = int'($urandom_range(16)) - 8;
      bx0 = int'($urandom_range(16)) - 8; by0 = int'($urandom_range(16)) - 8;
      bx1 = int'($urandom_range(16)) - 8; by1 = int'($urandom_range(16)) - 8;
    end
    // corner order is free per box and axis
    if ($urandom_range(1)) begin t = ax0; ax0 = ax1; ax1 = t; end
    if ($urandom_range(1)) begin t = ay0; ay0 = ay1; ay1 = t; end
    if ($urandom_range(1)) begin t = bx0; bx0 = bx1; bx1 = t; end
    if ($urandom_range(1)) begin t = by0; by0 = by1; by1 = t; end
    send_boxes(ax0, ay0, ax1, ay1, bx0, by0, bx1, by1);
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: identical, disjoint, touching, degenerate, nested, extremes.
    send_boxes(0, 0, 10, 10, 0, 0, 10, 10);
    send_boxes(10, 10, 0, 0, 0, 10, 10, 0);
    send_boxes(0, 0, 10, 10, 20, 20, 30, 30);
    send_boxes(0, 0, 10, 10, 10, 0, 20, 10);
    send_boxes(0, 0, 10, 10, 0, 10, 10, 20);
    send_boxes(0, 0, 10, 10, 5, 20, 8, 30);
    send_boxes(5, 5, 5, 9, 0, 0, 10, 10);
    send_boxes(0, 0, 10, 10, 2, 7, 8, 7);
    send_boxes(0, 0, 0, 0, 0, 0, 0, 0);
    send_boxes(0, 0, 10, 10, 5, 5, 15, 15);
    send_boxes(0, 0, 100, 100, 10, 10, 20, 20);
    send_boxes(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    send_boxes(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768);
    send_boxes(-32768, -32768, 32767, 32767, 0, 0, 1, 1);
    send_boxes(-32768, -32768, 32767, 32767, -32768, -32768, -32767, -32767);
    send_boxes(32766, 32766, 32767, 32767, -32768, -32768, 32767, 32767);
    send_boxes(-32768, -32768, 0, 0, 0, 0, 32767, 32767);
    send_boxes(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
    send_boxes(-1, -1, 1, 1, 0, 0, 2, 2);
    send_boxes(-32768, -32768, -32767, -32767, 32766, 32766, 32767, 32767);
    send_boxes(0, 0, 3, 1, 1, 0, 4, 1);
    send_boxes(0, 0, 3, 3, 1, 1, 2, 2);

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if (i == RANDOM_PAIRS / 3) begin
        send_idle_pct = 82;
        recv_idle_pct = 33;
      end else if (i == 2 * RANDOM_PAIRS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random_pair();
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    // drain window: a stray extra beat would show up here
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: a correct run ends far sooner.
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
